/* hdl/dcfe_pkg.sv */
// ----------------------------------------------------------------------------
// dcfe_pkg
// Types, constants and CRC helpers shared by the drive command frame encoder.
// ----------------------------------------------------------------------------
package dcfe_pkg;

    localparam int BYTE_W     = 8;
    localparam int DIR_W      = 2;
    localparam int CRC_W      = 16;
    localparam int FRAME_LEN  = 9;
    localparam int CRC_STAGES = 6;
    localparam int POS_W      = $clog2(FRAME_LEN);
    localparam int STAGE_W    = $clog2(CRC_STAGES);

    localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
    localparam logic [CRC_W-1:0] CRC_POLY = 16'hA001;

    localparam logic [BYTE_W-1:0] START_BYTE = 8'hFF;
    localparam logic [BYTE_W-1:0] CMD_BYTE   = 8'h07;
    localparam logic [BYTE_W-1:0] PAD_BYTE   = 8'h00;

    // direction codes and their flag bytes
    localparam logic [DIR_W-1:0] DIR_STOP  = 2'd0;
    localparam logic [DIR_W-1:0] DIR_CODE1 = 2'd1;
    localparam logic [DIR_W-1:0] DIR_CODE2 = 2'd2;
    localparam logic [DIR_W-1:0] DIR_CODE3 = 2'd3;

    localparam logic [BYTE_W-1:0] FLAG_STOP  = 8'd0;
    localparam logic [BYTE_W-1:0] FLAG_CODE1 = 8'd80;
    localparam logic [BYTE_W-1:0] FLAG_CODE2 = 8'd64;
    localparam logic [BYTE_W-1:0] FLAG_CODE3 = 8'd16;

    // frame byte positions
    localparam logic [POS_W-1:0] POS_START  = 4'd0;
    localparam logic [POS_W-1:0] POS_CMD    = 4'd1;
    localparam logic [POS_W-1:0] POS_LEFT   = 4'd2;
    localparam logic [POS_W-1:0] POS_PAD_A  = 4'd3;
    localparam logic [POS_W-1:0] POS_RIGHT  = 4'd4;
    localparam logic [POS_W-1:0] POS_PAD_B  = 4'd5;
    localparam logic [POS_W-1:0] POS_FLAG   = 4'd6;
    localparam logic [POS_W-1:0] POS_CRC_LO = 4'd7;
    localparam logic [POS_W-1:0] POS_CRC_HI = 4'd8;

    typedef struct packed {
        logic [BYTE_W-1:0] left_speed;
        logic [BYTE_W-1:0] right_speed;
        logic [BYTE_W-1:0] flag;
    } cmd_t;

    typedef struct packed {
        cmd_t              cmd;
        logic [CRC_W-1:0]  crc;
    } stage_t;

    function automatic logic [BYTE_W-1:0] dir_flag(input logic [DIR_W-1:0] dir);
        logic [BYTE_W-1:0] f;
        unique case (dir)
            DIR_STOP:  f = FLAG_STOP;
            DIR_CODE1: f = FLAG_CODE1;
            DIR_CODE2: f = FLAG_CODE2;
            DIR_CODE3: f = FLAG_CODE3;
            default:   f = FLAG_STOP;
        endcase
        return f;
    endfunction

    // one byte through the reflected crc, one bit per step
    function automatic logic [CRC_W-1:0] crc_add_byte(input logic [CRC_W-1:0] crc_in,
                                                      input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] c;
        c = crc_in ^ {{(CRC_W-BYTE_W){1'b0}}, b};
        for (int k = 0; k < BYTE_W; k++) begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

    // byte covered by crc stage idx (frame bytes 1 through 6)
    function automatic logic [BYTE_W-1:0] crc_stage_byte(input logic [STAGE_W-1:0] idx,
                                                         input cmd_t c);
        logic [BYTE_W-1:0] b;
        unique case (idx)
            3'd0:    b = CMD_BYTE;
            3'd1:    b = c.left_speed;
            3'd2:    b = PAD_BYTE;
            3'd3:    b = c.right_speed;
            3'd4:    b = PAD_BYTE;
            3'd5:    b = c.flag;
            default: b = PAD_BYTE;
        endcase
        return b;
    endfunction

endpackage

/* hdl/dcfe_cmd_if.sv */
// ----------------------------------------------------------------------------
// dcfe_cmd_if
// Drive command channel: valid/ready with speed and direction payload.
// ----------------------------------------------------------------------------
interface dcfe_cmd_if;
    logic       valid;
    logic       ready;
    logic [7:0] left_speed;
    logic [7:0] right_speed;
    logic [1:0] direction;

    modport source (output valid, output left_speed, output right_speed,
                    output direction, input ready);
    modport sink   (input valid, input left_speed, input right_speed,
                    input direction, output ready);
endinterface

/* hdl/dcfe_byte_if.sv */
// ----------------------------------------------------------------------------
// dcfe_byte_if
// Frame byte channel: valid/ready with one byte and a last marker.
// ----------------------------------------------------------------------------
interface dcfe_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       last;

    modport source (output valid, output frame_byte, output last, input ready);
    modport sink   (input valid, input frame_byte, input last, output ready);
endinterface

/* hdl/dcfe_crc_stage.sv */
// ----------------------------------------------------------------------------
// dcfe_crc_stage
// One pipeline stage: folds one frame byte into the running crc.
// ----------------------------------------------------------------------------
module dcfe_crc_stage (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  dcfe_pkg::stage_t          in_data,
    input  logic [dcfe_pkg::BYTE_W-1:0] crc_byte,
    output logic                      out_valid,
    input  logic                      out_ready,
    output dcfe_pkg::stage_t          out_data
);
    import dcfe_pkg::*;

    logic   valid_reg;
    stage_t data_reg;
    stage_t data_next;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        data_next     = in_data;
        data_next.crc = crc_add_byte(in_data.crc, crc_byte);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

/* hdl/dcfe_ser.sv */
// ----------------------------------------------------------------------------
// dcfe_ser
// Frame serializer: holds one finished command and sends its nine bytes.
// ----------------------------------------------------------------------------
module dcfe_ser (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  dcfe_pkg::stage_t              in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [dcfe_pkg::BYTE_W-1:0]   out_byte,
    output logic                          out_last
);
    import dcfe_pkg::*;

    logic             hold_valid_reg;
    logic [POS_W-1:0] pos_reg;
    stage_t           hold_reg;
    logic             last_byte;

    assign last_byte = (pos_reg == POS_CRC_HI);
    assign in_ready  = !hold_valid_reg || (out_ready && last_byte);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            pos_reg        <= POS_START;
        end
        else if (in_ready)
        begin
            hold_valid_reg <= in_valid;
            pos_reg        <= POS_START;
        end
        else if (out_ready)
        begin
            pos_reg <= pos_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            hold_reg <= in_data;
    end

    always_comb
    begin
        unique case (pos_reg)
            POS_START:  out_byte = START_BYTE;
            POS_CMD:    out_byte = CMD_BYTE;
            POS_LEFT:   out_byte = hold_reg.cmd.left_speed;
            POS_PAD_A:  out_byte = PAD_BYTE;
            POS_RIGHT:  out_byte = hold_reg.cmd.right_speed;
            POS_PAD_B:  out_byte = PAD_BYTE;
            POS_FLAG:   out_byte = hold_reg.cmd.flag;
            POS_CRC_LO: out_byte = hold_reg.crc[BYTE_W-1:0];
            POS_CRC_HI: out_byte = hold_reg.crc[CRC_W-1:BYTE_W];
            default:    out_byte = PAD_BYTE;
        endcase
    end

    assign out_valid = hold_valid_reg;
    assign out_last  = last_byte;

endmodule

/* hdl/drive_command_frame_encoder.sv */
// ----------------------------------------------------------------------------
// drive_command_frame_encoder
// Turns drive commands into nine-byte frames protected by CRC-16/MODBUS.
// ----------------------------------------------------------------------------
// usage
//   cmd   : sink channel, one transaction per drive command (left speed,
//           right speed, 2-bit direction code)
//   frame : source channel, nine transactions per command in order
//           FF 07 left 00 right 00 flag crc_lo crc_hi; last marks crc_hi
//   first byte: a frame's first byte is offered once its command has
//           passed the six crc stages into the serializer hold register
//   throughput: one command per nine frame bytes, set by the byte-wide
//           frame channel; the six crc stages (one byte each) accept a
//           new command in every cycle while the next stage can take it,
//           so up to six commands queue behind the frame being sent
//   reset: all valid bits clear; nothing is held, no frame is offered
//   stall: when frame.ready is low the current byte holds, the pipeline
//           fills, then cmd.ready drops; nothing is lost or repeated
// ----------------------------------------------------------------------------
module drive_command_frame_encoder (
    input  logic        clk,
    input  logic        rst_n,
    dcfe_cmd_if.sink    cmd,
    dcfe_byte_if.source frame
);
    import dcfe_pkg::*;

    logic   pipe_valid [0:CRC_STAGES];
    logic   pipe_ready [0:CRC_STAGES];
    stage_t pipe_data  [0:CRC_STAGES];

    // stage 0 input: pass fields, look up the flag, seed the crc
    assign pipe_valid[0]              = cmd.valid;
    assign cmd.ready                  = pipe_ready[0];
    assign pipe_data[0].cmd.left_speed  = cmd.left_speed;
    assign pipe_data[0].cmd.right_speed = cmd.right_speed;
    assign pipe_data[0].cmd.flag        = dir_flag(cmd.direction);
    assign pipe_data[0].crc             = CRC_INIT;

    for (genvar k = 0; k < CRC_STAGES; k++)
    begin : g_crc
        dcfe_crc_stage u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (pipe_valid[k]),
            .in_ready  (pipe_ready[k]),
            .in_data   (pipe_data[k]),
            .crc_byte  (crc_stage_byte(STAGE_W'(k), pipe_data[k].cmd)),
            .out_valid (pipe_valid[k+1]),
            .out_ready (pipe_ready[k+1]),
            .out_data  (pipe_data[k+1])
        );
    end

    dcfe_ser u_ser (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pipe_valid[CRC_STAGES]),
        .in_ready  (pipe_ready[CRC_STAGES]),
        .in_data   (pipe_data[CRC_STAGES]),
        .out_valid (frame.valid),
        .out_ready (frame.ready),
        .out_byte  (frame.frame_byte),
        .out_last  (frame.last)
    );

endmodule

/* bench/dcfe_frame_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcfe_frame_checker
// Watches the command and frame channels of the drive command frame encoder.
// Builds the expected nine-byte frame with its CRC-16/MODBUS for every
// accepted command and compares each accepted frame byte against it.
// ----------------------------------------------------------------------------
module dcfe_frame_checker (
    input  logic  clk,
    input  logic  rst_n,
    dcfe_cmd_if   cmd,
    dcfe_byte_if  frame,
    output int    mismatch_count,
    output int    bytes_outstanding
);
    import dcfe_pkg::*;

    localparam int REPORT_LIMIT = 100;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
    } frame_beat_t;

    frame_beat_t frame_bytes_due[$];
    int          error_total = 0;

    function automatic logic [BYTE_W-1:0] direction_flag(input logic [DIR_W-1:0] dir);
        logic [BYTE_W-1:0] flag;
        case (dir)
            DIR_STOP:  flag = FLAG_STOP;
            DIR_CODE1: flag = FLAG_CODE1;
            DIR_CODE2: flag = FLAG_CODE2;
            default:   flag = FLAG_CODE3;
        endcase
        return flag;
    endfunction

    // bit-serial form: feedback is crc lsb xor data bit, lsb first
    function automatic logic [CRC_W-1:0] modbus_crc_step(input logic [CRC_W-1:0] crc,
                                                         input logic [BYTE_W-1:0] data);
        logic [CRC_W-1:0] acc;
        logic             fb;
        acc = crc;
        for (int i = 0; i < BYTE_W; i++)
        begin
            fb  = acc[0] ^ data[i];
            acc = acc >> 1;
            if (fb)
            begin
                acc = acc ^ CRC_POLY;
            end
        end
        return acc;
    endfunction

    task automatic queue_command_frame(input logic [BYTE_W-1:0] left_speed,
                                       input logic [BYTE_W-1:0] right_speed,
                                       input logic [DIR_W-1:0]  dir);
        logic [BYTE_W-1:0] frame_bytes [FRAME_LEN];
        logic [CRC_W-1:0]  crc;
        frame_beat_t       beat;
        frame_bytes[0] = START_BYTE;
        frame_bytes[1] = CMD_BYTE;
        frame_bytes[2] = left_speed;
        frame_bytes[3] = PAD_BYTE;
        frame_bytes[4] = right_speed;
        frame_bytes[5] = PAD_BYTE;
        frame_bytes[6] = direction_flag(dir);
        // start byte is not covered
        crc = CRC_INIT;
        for (int i = 1; i <= 6; i++)
        begin
            crc = modbus_crc_step(crc, frame_bytes[i]);
        end
        frame_bytes[7] = crc[7:0];
        frame_bytes[8] = crc[15:8];
        for (int i = 0; i < FRAME_LEN; i++)
        begin
            beat.data = frame_bytes[i];
            beat.last = (i == FRAME_LEN - 1);
            frame_bytes_due.push_back(beat);
        end
    endtask

    always @(posedge clk)
    begin
        frame_beat_t due;
        if (rst_n)
        begin
            if (cmd.valid && cmd.ready)
            begin
                queue_command_frame(cmd.left_speed, cmd.right_speed, cmd.direction);
            end
            if (frame.valid && frame.ready)
            begin
                if (frame_bytes_due.size() == 0)
                begin
                    if (error_total < REPORT_LIMIT)
                    begin
                        $display("%0t: unexpected transaction, expected none, got %02h/%0b",
                                 $time, frame.frame_byte, frame.last);
                    end
                    error_total++;
                end
                else
                begin
                    due = frame_bytes_due.pop_front();
                    if (frame.frame_byte !== due.data || frame.last !== due.last)
                    begin
                        if (error_total < REPORT_LIMIT)
                        begin
                            $display("%0t: mismatch, expected %02h/%0b, got %02h/%0b",
                                     $time, due.data, due.last,
                                     frame.frame_byte, frame.last);
                        end
                        error_total++;
                    end
                end
            end
        end
        bytes_outstanding <= frame_bytes_due.size();
        mismatch_count    <= error_total;
    end

endmodule

/* bench/tb_drive_command_frame_encoder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_drive_command_frame_encoder
// Drives drive commands into the frame encoder in random bursts while the
// frame side stalls in changing patterns; the frame checker predicts and
// compares every byte. Directed extremes first, then random commands.
// ----------------------------------------------------------------------------
module tb_drive_command_frame_encoder;
    import dcfe_pkg::*;

    localparam int RESET_CYCLES    = 5;
    localparam int RANDOM_COMMANDS = 250;
    localparam int IDLE_LIMIT      = 2000;
    localparam int DRAIN_CYCLES    = 20;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_RANDOM,
        STALL_PERIODIC
    } stall_mode_t;

    logic clk = 1'b0;
    logic rst_n;
    int   mismatch_count;
    int   bytes_outstanding;

    dcfe_cmd_if  cmd();
    dcfe_byte_if frame();

    drive_command_frame_encoder DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .frame (frame)
    );

    dcfe_frame_checker u_frame_check (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .frame             (frame),
        .mismatch_count    (mismatch_count),
        .bytes_outstanding (bytes_outstanding)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic send_drive_command(input logic [BYTE_W-1:0] left_speed,
                                      input logic [BYTE_W-1:0] right_speed,
                                      input logic [DIR_W-1:0]  dir);
        cmd.valid       <= 1'b1;
        cmd.left_speed  <= left_speed;
        cmd.right_speed <= right_speed;
        cmd.direction   <= dir;
        do
        begin
            @(posedge clk);
        end
        while (!cmd.ready);
    endtask

    task automatic hold_off_sender(input int cycles);
        cmd.valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // extremes show up more often than a flat spread would give
    function automatic logic [BYTE_W-1:0] pick_speed();
        logic [BYTE_W-1:0] speed;
        case ($urandom_range(0, 9))
            0:       speed = 8'h00;
            1:       speed = 8'hFF;
            default: speed = BYTE_W'($urandom_range(0, 255));
        endcase
        return speed;
    endfunction

    // receiver: switches between no stall, random stall and periodic stall
    initial
    begin
        stall_mode_t mode;
        int          mode_left;
        int          period;
        int          phase;
        mode      = STALL_NONE;
        mode_left = 0;
        period    = 2;
        phase     = 0;
        frame.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (mode_left == 0)
            begin
                mode      = stall_mode_t'($urandom_range(0, 2));
                mode_left = $urandom_range(40, 200);
                period    = $urandom_range(2, 9);
                phase     = 0;
            end
            mode_left--;
            phase = (phase + 1 < period) ? phase + 1 : 0;
            case (mode)
                STALL_NONE:     frame.ready <= 1'b1;
                STALL_RANDOM:   frame.ready <= ($urandom_range(0, 3) != 0);
                default:        frame.ready <= (phase >= period / 2);
            endcase
        end
    end

    // ends the run when nothing moves on either channel for too long
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((cmd.valid && cmd.ready) || (frame.valid && frame.ready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
        end
        $display("drive_command_frame_encoder verification failed");
        $finish;
    end

    initial
    begin
        int               burst_left;
        int               gap;
        logic [BYTE_W-1:0] walk;
        rst_n           <= 1'b0;
        cmd.valid       <= 1'b0;
        cmd.left_speed  <= '0;
        cmd.right_speed <= '0;
        cmd.direction   <= DIR_STOP;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: field extremes, every direction, back to back
        send_drive_command(8'h00, 8'h00, DIR_STOP);
        send_drive_command(8'hFF, 8'hFF, DIR_CODE3);
        send_drive_command(8'h00, 8'hFF, DIR_CODE1);
        send_drive_command(8'hFF, 8'h00, DIR_CODE2);
        send_drive_command(8'h55, 8'hAA, DIR_STOP);
        send_drive_command(8'hAA, 8'h55, DIR_CODE1);
        send_drive_command(8'h7F, 8'hFE, DIR_CODE2);
        send_drive_command(8'h80, 8'h01, DIR_CODE3);
        for (int i = 0; i < BYTE_W; i++)
        begin
            walk = 8'h01 << i;
            send_drive_command(walk, ~walk, DIR_W'(i));
        end
        hold_off_sender($urandom_range(1, 12));

        burst_left = 0;
        for (int n = 0; n < RANDOM_COMMANDS; n++)
        begin
            if (burst_left == 0)
            begin
                gap = $urandom_range(0, 12);
                if (gap > 0)
                begin
                    hold_off_sender(gap);
                end
                // now and then a long stretch with no gaps at all
                burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                        : $urandom_range(1, 8);
            end
            burst_left--;
            send_drive_command(pick_speed(), pick_speed(), DIR_W'($urandom_range(0, 3)));
        end
        cmd.valid <= 1'b0;
        // let the checker count the last command before waiting on it
        @(posedge clk);

        while (bytes_outstanding != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && bytes_outstanding == 0)
        begin
            $display("drive_command_frame_encoder verification clean");
        end
        else
        begin
            $display("drive_command_frame_encoder verification failed");
        end
        $finish;
    end

endmodule
